@@ hdl/mds_pkg.sv @@
// ----------------------------------------------------------------------------
// mds_pkg: shared types and constants for max_duration_similarity
// Payload structs, queue entry flags and the back-end sequencer states.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int unsigned DURATION_BITS_DEF = 32;
  localparam int unsigned SIM_FRAC_BITS     = 16;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  localparam int unsigned IN_DUR_BITS  = 32;
  localparam int unsigned OUT_SIM_BITS = SIM_FRAC_BITS + 1;

  typedef struct packed {
    logic [IN_DUR_BITS-1:0] duration_first;
    logic [IN_DUR_BITS-1:0] duration_second;
    logic                   last_pair;
  } mds_in_t;

  typedef struct packed {
    logic [OUT_SIM_BITS-1:0] best_similarity;
    logic                    found;
  } mds_out_t;

  // classification attached to each queued pair
  typedef struct packed {
    logic skip;
    logic last;
  } mds_flags_t;

  localparam int unsigned FLAGS_BITS = $bits(mds_flags_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } mds_state_e;

endpackage

@@ hdl/max_duration_similarity.sv @@
// ----------------------------------------------------------------------------
// max_duration_similarity: best min/max ratio over a set of duration pairs
// A pair that is not both zero goes through the divider: pop, one quotient
// bit per cycle over SIM_FRAC_BITS + 1 bits, then compare. A pair that is both
// zero is popped without a division; a last pair then holds the back end in
// ST_OUT while the output is stalled, and out_valid_o is registered.
// Async active-low reset clears the control state, not the data registers.
// ----------------------------------------------------------------------------
module max_duration_similarity import mds_pkg::*; #(
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mds_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mds_out_t out_data_o
);

  localparam int unsigned ENTRY_BITS = FLAGS_BITS + 2 * DURATION_BITS;

  logic                     q_full;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_not_empty;
  logic [DURATION_BITS-1:0] f_hi, f_lo;
  mds_flags_t               f_flags;
  logic [ENTRY_BITS-1:0]    push_entry;
  logic [ENTRY_BITS-1:0]    head_entry;
  logic [DURATION_BITS-1:0] h_hi, h_lo;
  mds_flags_t               h_flags;

  mds_front #(
    .DURATION_BITS(DURATION_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_hi_o     (f_hi),
    .q_lo_o     (f_lo),
    .q_flags_o  (f_flags)
  );

  assign push_entry = {f_flags, f_hi, f_lo};

  mds_queue #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (head_entry)
  );

  assign {h_flags, h_hi, h_lo} = head_entry;

  mds_back #(
    .DURATION_BITS(DURATION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_pop_o       (q_pop),
    .q_hi_i        (h_hi),
    .q_lo_i        (h_lo),
    .q_flags_i     (h_flags),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

@@ hdl/mds_front.sv @@
// ----------------------------------------------------------------------------
// mds_front: input side of max_duration_similarity
// Accepts pairs, trims them to the working width, orders them into
// divisor and dividend and marks pairs that are both zero.
// ----------------------------------------------------------------------------
module mds_front import mds_pkg::*; #(
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  mds_in_t                  in_data_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output logic [DURATION_BITS-1:0] q_hi_o,
  output logic [DURATION_BITS-1:0] q_lo_o,
  output mds_flags_t               q_flags_o
);

  logic [DURATION_BITS-1:0] dur_a;
  logic [DURATION_BITS-1:0] dur_b;
  logic                     a_gt_b;

  assign dur_a  = DURATION_BITS'(in_data_i.duration_first);
  assign dur_b  = DURATION_BITS'(in_data_i.duration_second);
  assign a_gt_b = dur_a > dur_b;

  assign q_hi_o = a_gt_b ? dur_a : dur_b;
  assign q_lo_o = a_gt_b ? dur_b : dur_a;

  // hi is zero only when both durations are zero
  assign q_flags_o.skip = (q_hi_o == '0);
  assign q_flags_o.last = in_data_i.last_pair;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

@@ hdl/mds_queue.sv @@
// ----------------------------------------------------------------------------
// mds_queue: small fifo between front and back end
// Register-based queue with occupancy count; head is visible while not empty.
// ----------------------------------------------------------------------------
module mds_queue import mds_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/mds_back.sv @@
// ----------------------------------------------------------------------------
// mds_back: execution side of max_duration_similarity
// Restoring divider for lo/hi one quotient bit per cycle, running maximum
// over the set and the result register toward the output channel.
// ----------------------------------------------------------------------------
module mds_back import mds_pkg::*; #(
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_not_empty_i,
  output logic                     q_pop_o,
  input  logic [DURATION_BITS-1:0] q_hi_i,
  input  logic [DURATION_BITS-1:0] q_lo_i,
  input  mds_flags_t               q_flags_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mds_out_t                 out_data_o
);

  localparam int unsigned DW = DURATION_BITS;
  localparam int unsigned QW = SIM_FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);

  mds_state_e    state_q, state_d;
  logic [DW-1:0] hi_q, hi_d;
  logic [DW:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last_q, last_d;
  logic [QW-1:0] best_q, best_d;
  logic          seen_q, seen_d;
  logic          out_valid_q, out_valid_d;
  mds_out_t      out_data_q, out_data_d;

  logic          slot_free;
  logic          rem_ge;
  logic [DW:0]   rem_sub;

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign rem_ge    = rem_q >= {1'b0, hi_q};
  assign rem_sub   = rem_q - {1'b0, hi_q};

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    hi_d        = hi_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    best_d      = best_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_not_empty_i) begin
          q_pop_o = 1'b1;
          hi_d    = q_hi_i;
          rem_d   = {1'b0, q_lo_i};
          quo_d   = '0;
          cnt_d   = '0;
          last_d  = q_flags_i.last;
          if (!q_flags_i.skip) begin
            state_d = ST_DIV;
          end else if (q_flags_i.last) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        // compare and subtract, then shift for the next quotient bit
        quo_d = {quo_q[QW-2:0], rem_ge};
        rem_d = (rem_ge ? rem_sub : rem_q) << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!seen_q || quo_q > best_q) begin
          best_d = quo_q;
        end
        seen_d  = 1'b1;
        state_d = last_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_d                = 1'b1;
          out_data_d.best_similarity = seen_q ? OUT_SIM_BITS'(best_q) : '0;
          out_data_d.found           = seen_q;
          best_d                     = '0;
          seen_d                     = 1'b0;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      best_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      best_q      <= best_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

endmodule

@@ tb/mds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_checker: scoreboard for max_duration_similarity
// Watches both channels, predicts the best min/max ratio of every set and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module mds_checker import mds_pkg::*; #(
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  mds_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  mds_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [63:0] DUR_MASK = (64'd1 << DURATION_BITS) - 64'd1;
  localparam logic [63:0] SIM_MASK = (64'd1 << (SIM_FRAC_BITS + 1)) - 64'd1;

  mds_out_t                expected_best_q[$];
  mds_out_t                want;
  logic [OUT_SIM_BITS-1:0] set_best;
  logic                    set_found;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    set_best     = '0;
    set_found    = 1'b0;
  end

  // restoring division lo/hi with SIM_FRAC_BITS fraction bits, truncated
  function automatic logic [OUT_SIM_BITS-1:0] min_max_ratio(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] rem;
    logic [63:0] quo;
    int          i;
    rem = lo;
    quo = '0;
    if (rem >= hi) begin
      quo = 64'd1;
      rem = rem - hi;
    end
    for (i = 0; i < SIM_FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= hi) begin
        rem    = rem - hi;
        quo[0] = 1'b1;
      end
    end
    quo = quo & SIM_MASK;
    return quo[OUT_SIM_BITS-1:0];
  endfunction

  task automatic track_pair(input mds_in_t item);
    logic [63:0]             a;
    logic [63:0]             b;
    logic [OUT_SIM_BITS-1:0] sim;
    mds_out_t                res;
    a = 64'(item.duration_first) & DUR_MASK;
    b = 64'(item.duration_second) & DUR_MASK;
    if (a != 0 || b != 0) begin
      sim = (a > b) ? min_max_ratio(b, a) : min_max_ratio(a, b);
      if (!set_found || sim > set_best) set_best = sim;
      set_found = 1'b1;
    end
    if (item.last_pair) begin
      res.best_similarity = set_found ? set_best : '0;
      res.found           = set_found;
      expected_best_q     = {expected_best_q, res};
      set_best  = '0;
      set_found = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      set_best  = '0;
      set_found = 1'b0;
    end else begin
      // results always trail their last pair, so check before predicting
      if (out_valid_i && !out_stall_i) begin
        if (expected_best_q.size() == 0) begin
          $error("result transaction with nothing expected: best_similarity %0d found %0b",
                 out_data_i.best_similarity, out_data_i.found);
          fail_count_o++;
        end else begin
          want = expected_best_q.pop_front();
          if (out_data_i.best_similarity !== want.best_similarity) begin
            $error("best_similarity mismatch: expected %0d, actual %0d",
                   want.best_similarity, out_data_i.best_similarity);
            fail_count_o++;
          end
          if (out_data_i.found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, out_data_i.found);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) track_pair(in_data_i);
      pending_o = expected_best_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for max_duration_similarity
// Drives directed and random sets of duration pairs under varying idle and
// stall rates, with a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mds_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  mds_in_t     in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  mds_out_t    out_data;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle_pct  = 21;
  int unsigned recv_stall_pct = 83;
  int unsigned pairs_sent     = 0;
  int unsigned hold_left      = 0;
  logic        hold_req       = 1'b0;

  always #10 clk_i = ~clk_i;

  max_duration_similarity u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  mds_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // output side: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_pair(input logic [IN_DUR_BITS-1:0] first,
                           input logic [IN_DUR_BITS-1:0] second, input logic last);
    mds_in_t item;
    item.duration_first  = first;
    item.duration_second = second;
    item.last_pair       = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    pairs_sent++;
  endtask

  task automatic send_random_pair(input logic last, input logic zero_set);
    logic [IN_DUR_BITS-1:0] a;
    logic [IN_DUR_BITS-1:0] b;
    int unsigned            style;
    style = zero_set ? 0 : $urandom_range(0, 9);
    a     = $urandom;
    b     = $urandom;
    case (style)
      0: begin
        a = '0;
        b = '0;
      end
      1: begin
        if ($urandom_range(1)) a = '0;
        else b = '0;
      end
      2: b = a;
      3: b = a + $urandom_range(0, 3);
      4, 5: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      default: ;
    endcase
    send_pair(a, b, last);
  endtask

  task automatic run_random_sets(input int unsigned budget);
    int unsigned stop_at;
    int unsigned set_len;
    int unsigned k;
    logic        zero_set;
    stop_at = pairs_sent + budget;
    while (pairs_sent < stop_at) begin
      set_len  = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      zero_set = ($urandom_range(14) == 0);
      for (k = 1; k <= set_len; k++) send_random_pair(k == set_len, zero_set);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (30) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty sets, equal durations, extremes, multi-pair sets
    send_pair(32'h0, 32'h0, 1'b1);
    send_pair(32'h0, 32'h0, 1'b0);
    send_pair(32'h0, 32'h0, 1'b1);
    send_pair(32'h0005_0000, 32'h0005_0000, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_pair(32'h0, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h1, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'h1, 1'b0);
    send_pair(32'h0, 32'h0, 1'b0);
    send_pair(32'h0001_0000, 32'h0003_0000, 1'b0);
    send_pair(32'h0003_0000, 32'h0002_0000, 1'b0);
    send_pair(32'h7, 32'h9, 1'b1);
    // a zero similarity still counts as found
    send_pair(32'h0, 32'h7, 1'b0);
    send_pair(32'h0, 32'h0, 1'b1);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_pair(32'h1, 32'h1, 1'b0);
    send_pair(32'h2, 32'h3, 1'b1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

    run_random_sets(360);
    drain();

    send_idle_pct  = 83;
    recv_stall_pct = 21;
    run_random_sets(360);
    drain();

    // no idling; hold the output off so the block backs up into its input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    run_random_sets(380);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS max_duration_similarity");
    end else begin
      $display("FAIL max_duration_similarity");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("FAIL max_duration_similarity");
    $finish;
  end

endmodule

@@ files.f @@
hdl/mds_pkg.sv
hdl/mds_front.sv
hdl/mds_queue.sv
hdl/mds_back.sv
hdl/max_duration_similarity.sv
tb/mds_checker.sv
tb/testbench.sv
